// ----- rtl/nmit_pkg.sv -----
// Shared widths, stage indexes and types for the normal matrix inverse-transpose block.
// No dependencies; used by nmit_div and normal_matrix_inverse_transpose_top.
`timescale 1ns / 1ps
`default_nettype none

package nmit_pkg;

    // element and intermediate widths
    localparam int W_IN  = 16;             // Q4.12 input element
    localparam int W_P   = 2 * W_IN;       // element product
    localparam int W_C   = W_P + 1;        // cofactor, scale 2^24
    localparam int W_DP  = W_IN + W_C;     // element times cofactor
    localparam int W_DET = W_DP + 2;       // sum of three terms, scale 2^36
    localparam int W_MAG = W_C - 1;        // cofactor magnitude
    localparam int W_DEN = W_DET - 1;      // determinant magnitude
    localparam int NUM_SHIFT = 28;         // Q24 / Q36 -> Q16
    localparam int W_N   = W_MAG + NUM_SHIFT + 2;  // 2*num + den
    localparam int W_D   = W_DEN + 1;      // 2*den
    localparam int W_Q   = 33;             // quotient bits kept before clamping
    localparam int W_X   = W_D + W_Q;      // shifted divisor compare width
    localparam int W_OUT = 32;             // Q16.16 result

    // pipeline stage indexes
    localparam int S_PROD = 0;
    localparam int S_COF  = 1;
    localparam int S_DETP = 2;
    localparam int S_DET  = 3;
    localparam int S_DEN  = 4;
    localparam int S_OVF  = 5;
    localparam int S_DIV0 = 6;
    localparam int S_OUT  = S_DIV0 + W_Q;
    localparam int NS     = S_OUT + 1;

    // sideband that rides with each quotient lane
    typedef struct packed {
        logic neg;   // result negative
        logic ovf;   // quotient at least 2^W_Q
    } t_side;

endpackage

`default_nettype wire

// ----- rtl/normal_matrix_inverse_transpose_top.sv -----
// Each matrix passes products, cofactors, expansion terms, determinant, magnitudes, range
// check, 33 bit-per-stage dividers and output register; one matrix per cycle unless stalled.
// A stage takes new data when it is empty or the stage after it moves, so bubbles fill.
// Reset (synchronous, active low) clears all stage valid bits; payload is not reset.
// Depends on nmit_pkg and nmit_div.
`timescale 1ns / 1ps
`default_nettype none

module normal_matrix_inverse_transpose_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
    input  wire logic [143:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // n00, n01, n02, n10, n11, n12, n20, n21, n22 (32 bits each, lowest first)
    output logic [287:0]      o_m_axis_tdata,
    // bit 0 singular, bit 1 saturated
    output logic [1:0]        o_m_axis_tuser
);

    localparam int W_IN  = nmit_pkg::W_IN;
    localparam int W_P   = nmit_pkg::W_P;
    localparam int W_C   = nmit_pkg::W_C;
    localparam int W_DP  = nmit_pkg::W_DP;
    localparam int W_DET = nmit_pkg::W_DET;
    localparam int W_MAG = nmit_pkg::W_MAG;
    localparam int W_DEN = nmit_pkg::W_DEN;
    localparam int W_N   = nmit_pkg::W_N;
    localparam int W_D   = nmit_pkg::W_D;
    localparam int W_Q   = nmit_pkg::W_Q;
    localparam int W_X   = nmit_pkg::W_X;
    localparam int W_OUT = nmit_pkg::W_OUT;
    localparam int NS    = nmit_pkg::NS;

    // product operand indexes: cofactor i = product 2i minus product 2i+1
    localparam int PX [18] = '{4, 5, 5, 3, 3, 4, 2, 1, 0, 2, 1, 0, 1, 2, 2, 0, 0, 1};
    localparam int PY [18] = '{8, 7, 6, 8, 7, 6, 7, 8, 8, 6, 6, 7, 5, 4, 3, 5, 4, 3};

    localparam logic [W_Q-1:0]   POS_MAX = W_Q'(33'h07FFFFFFF);
    localparam logic [W_Q-1:0]   NEG_MAX = W_Q'(33'h080000000);
    localparam logic [W_OUT-1:0] SAT_POS = 32'h7FFFFFFF;
    localparam logic [W_OUT-1:0] SAT_NEG = 32'h80000000;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    logic signed [W_IN-1:0]  w_a    [9];
    logic signed [W_P-1:0]   r_p    [18];
    logic signed [W_IN-1:0]  r_a0   [3];
    logic signed [W_C-1:0]   r_c1   [9];
    logic signed [W_IN-1:0]  r_a1   [3];
    logic signed [W_DP-1:0]  r_dp   [3];
    logic signed [W_C-1:0]   r_c2   [9];
    logic signed [W_DET-1:0] r_det;
    logic signed [W_C-1:0]   r_c3   [9];
    logic signed [W_DET-1:0] w_det_neg;
    logic        [W_DEN-1:0] w_den;
    logic        [W_N-1:0]   r_n4   [9];
    logic        [W_D-1:0]   r_d4;
    logic        [8:0]       r_neg4;
    logic        [W_N-1:0]   r_n5   [9];
    logic        [W_D-1:0]   r_d5;
    logic        [8:0]       r_neg5;
    logic        [8:0]       r_ovf5;
    logic [nmit_pkg::S_OUT-1:nmit_pkg::S_DEN] r_sg;

    logic [W_Q-1:0]   w_quo  [9];
    nmit_pkg::t_side  w_side [9];
    logic [W_OUT-1:0] w_val  [9];
    logic [8:0]       w_sat;
    logic [287:0]     r_data;
    logic [1:0]       r_user;

    // flow control: a stage moves when it is empty or its successor moves
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // unpack elements
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_a[i] = $signed(i_s_axis_tdata[i*W_IN +: W_IN]);
        end
    end

    // element products
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_PROD]) begin
            for (int i = 0; i < 18; i++) begin
                r_p[i] <= w_a[PX[i]] * w_a[PY[i]];
            end
            for (int i = 0; i < 3; i++) begin
                r_a0[i] <= w_a[i];
            end
        end
    end

    // cofactors
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_COF]) begin
            for (int i = 0; i < 9; i++) begin
                r_c1[i] <= W_C'(r_p[2*i]) - W_C'(r_p[2*i+1]);
            end
            r_a1 <= r_a0;
        end
    end

    // first-row expansion terms
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_DETP]) begin
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= r_a1[i] * r_c1[i];
            end
            r_c2 <= r_c1;
        end
    end

    // determinant
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_DET]) begin
            r_det <= W_DET'(r_dp[0]) + W_DET'(r_dp[1]) + W_DET'(r_dp[2]);
            r_c3  <= r_c2;
        end
    end

    // magnitudes, rounded numerators and doubled divisor
    assign w_det_neg = -r_det;
    assign w_den = r_det[W_DET-1] ? w_det_neg[W_DEN-1:0] : r_det[W_DEN-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_DEN]) begin
            for (int i = 0; i < 9; i++) begin
                logic signed [W_C-1:0] v_cn;
                logic        [W_MAG-1:0] v_mag;
                v_cn  = -r_c3[i];
                v_mag = r_c3[i][W_C-1] ? v_cn[W_MAG-1:0] : r_c3[i][W_MAG-1:0];
                r_n4[i]   <= (W_N'(v_mag) << (nmit_pkg::NUM_SHIFT + 1)) + W_N'(w_den);
                r_neg4[i] <= r_c3[i][W_C-1] ^ r_det[W_DET-1];
            end
            r_d4 <= {w_den, 1'b0};
        end
    end

    // quotient range check against 2^W_Q
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_OVF]) begin
            for (int i = 0; i < 9; i++) begin
                r_ovf5[i] <= {{(W_X-W_N){1'b0}}, r_n4[i]} >= {r_d4, {W_Q{1'b0}}};
            end
            r_n5   <= r_n4;
            r_d5   <= r_d4;
            r_neg5 <= r_neg4;
        end
    end

    // mark a zero determinant and carry the singular flag down the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_DEN]) begin
            r_sg[nmit_pkg::S_DEN] <= (r_det == '0);
        end
        for (int k = nmit_pkg::S_OVF; k < nmit_pkg::S_OUT; k++) begin
            if (w_en[k]) begin
                r_sg[k] <= r_sg[k-1];
            end
        end
    end

    // nine divider lanes
    genvar g;
    generate
        for (g = 0; g < 9; g++) begin : g_lane
            nmit_div u_div (
                .i_clk  (i_clk),
                .i_en   (w_en[nmit_pkg::S_OUT-1:nmit_pkg::S_DIV0]),
                .i_rem  (r_n5[g]),
                .i_den  (r_d5),
                .i_side ({r_neg5[g], r_ovf5[g]}),
                .o_quo  (w_quo[g]),
                .o_side (w_side[g])
            );
        end
    endgenerate

    // apply sign and clamp
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            logic [W_Q-1:0] v_qn;
            v_qn = -w_quo[i];
            w_sat[i] = 1'b0;
            w_val[i] = '0;
            if (w_side[i].ovf) begin
                w_sat[i] = 1'b1;
                w_val[i] = w_side[i].neg ? SAT_NEG : SAT_POS;
            end else if (w_quo[i] != '0) begin
                if (w_side[i].neg) begin
                    w_sat[i] = w_quo[i] > NEG_MAX;
                    w_val[i] = w_sat[i] ? SAT_NEG : v_qn[W_OUT-1:0];
                end else begin
                    w_sat[i] = w_quo[i] > POS_MAX;
                    w_val[i] = w_sat[i] ? SAT_POS : w_quo[i][W_OUT-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en[nmit_pkg::S_OUT]) begin
            for (int i = 0; i < 9; i++) begin
                r_data[i*W_OUT +: W_OUT] <= r_sg[nmit_pkg::S_OUT-1] ? '0 : w_val[i];
            end
            r_user[0] <= r_sg[nmit_pkg::S_OUT-1];
            r_user[1] <= !r_sg[nmit_pkg::S_OUT-1] && (w_sat != '0);
        end
    end

    assign o_m_axis_tvalid = r_v[NS-1];
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_user;

    // a singular result is never flagged saturated
    a_sing_not_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("singular and saturated both set");

    // a singular result carries an all-zero matrix
    a_sing_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("singular result with nonzero elements");

    // input stalls only when the output is backed up
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

// ----- rtl/nmit_div.sv -----
// One lane of the pipelined restoring divider, one quotient bit per stage.
// Depends on nmit_pkg; stage enables come from the top-level flow control.
`timescale 1ns / 1ps
`default_nettype none

module nmit_div (
    input  wire logic                        i_clk,
    input  wire logic [nmit_pkg::W_Q-1:0]    i_en,
    input  wire logic [nmit_pkg::W_N-1:0]    i_rem,
    input  wire logic [nmit_pkg::W_D-1:0]    i_den,
    input  wire nmit_pkg::t_side             i_side,
    output logic      [nmit_pkg::W_Q-1:0]    o_quo,
    output nmit_pkg::t_side                  o_side
);

    localparam int WQ = nmit_pkg::W_Q;
    localparam int WN = nmit_pkg::W_N;
    localparam int WD = nmit_pkg::W_D;
    localparam int WX = nmit_pkg::W_X;

    logic [WN-1:0]   r_rem  [WQ];
    logic [WD-1:0]   r_den  [WQ];
    logic [WQ-1:0]   r_quo  [WQ];
    nmit_pkg::t_side r_side [WQ];

    genvar j;
    generate
        for (j = 0; j < WQ; j++) begin : g_stage
            logic [WN-1:0]   w_rem_in;
            logic [WD-1:0]   w_den_in;
            logic [WQ-1:0]   w_quo_in;
            nmit_pkg::t_side w_side_in;
            logic [WX-1:0]   w_dsh;
            logic [WX-1:0]   w_diff;
            logic            w_ge;

            if (j == 0) begin : g_first
                assign w_rem_in  = i_rem;
                assign w_den_in  = i_den;
                assign w_quo_in  = '0;
                assign w_side_in = i_side;
            end else begin : g_next
                assign w_rem_in  = r_rem[j-1];
                assign w_den_in  = r_den[j-1];
                assign w_quo_in  = r_quo[j-1];
                assign w_side_in = r_side[j-1];
            end

            // trial subtract of the divisor at this bit weight
            assign w_dsh  = {{WQ{1'b0}}, w_den_in} << (WQ - 1 - j);
            assign w_ge   = {{(WX-WN){1'b0}}, w_rem_in} >= w_dsh;
            assign w_diff = {{(WX-WN){1'b0}}, w_rem_in} - w_dsh;

            // advance remainder and quotient
            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j]  <= w_ge ? w_diff[WN-1:0] : w_rem_in;
                    r_den[j]  <= w_den_in;
                    r_quo[j]  <= w_quo_in | ({{(WQ-1){1'b0}}, w_ge} << (WQ - 1 - j));
                    r_side[j] <= w_side_in;
                end
            end
        end
    endgenerate

    assign o_quo  = r_quo[WQ-1];
    assign o_side = r_side[WQ-1];

endmodule

`default_nettype wire
